// ===== hw/rtl/vdb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdb_pkg
// shared widths, angle constants and the pipeline word type for the
// vector to degree bearing unit
// ----------------------------------------------------------------------------
package vdb_pkg;

  localparam int CompW       = 12;  // input component width
  localparam int MagW        = 12;  // magnitude width, holds 2048
  localparam int QuoW        = 6;   // quotient 0..45
  localparam int RemW        = 18;  // numerator 45 * 2048 and shifted divisor
  localparam int BrgW        = 9;   // bearing 0..360
  localparam int DivStages   = 3;
  localparam int DivBitsPerStage = QuoW / DivStages;
  localparam int NumStages   = DivStages + 2;  // prep, divider, placement

  localparam logic [QuoW-1:0] Eighth   = QuoW'(45);
  localparam logic [6:0]      Quarter  = 7'd90;
  localparam logic [BrgW-1:0] HalfTurn = BrgW'(180);
  localparam logic [BrgW-1:0] FullTurn = BrgW'(360);

  // error curve breakpoints
  localparam logic [QuoW-1:0] CorrSplit = QuoW'(22);
  localparam logic [QuoW-1:0] CorrHi0   = QuoW'(44);
  localparam logic [QuoW-1:0] CorrHi1   = QuoW'(41);
  localparam logic [QuoW-1:0] CorrHi2   = QuoW'(37);
  localparam logic [QuoW-1:0] CorrHi3   = QuoW'(32);
  localparam logic [QuoW-1:0] CorrLo0   = QuoW'(2);
  localparam logic [QuoW-1:0] CorrLo1   = QuoW'(6);
  localparam logic [QuoW-1:0] CorrLo2   = QuoW'(10);
  localparam logic [QuoW-1:0] CorrLo3   = QuoW'(15);

  // word carried through the divider stages
  typedef struct packed {
    logic [RemW-1:0] rem;   // partial remainder
    logic [MagW-1:0] den;   // larger magnitude
    logic [QuoW-1:0] quo;   // quotient bits so far
    logic            swap;  // |x| > |y|, mirror about 45 degrees
    logic            xneg;
    logic            yneg;
    logic            zero;  // both components zero
  } vdb_div_t;

endpackage

// ===== hw/rtl/vdb_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdb_prep
// first stage: magnitudes, octant compare and the scaled numerator
// ----------------------------------------------------------------------------
module vdb_prep import vdb_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CompW-1:0] x_value,
  input  logic signed [CompW-1:0] y_value,
  output vdb_div_t                dout
);

  logic [MagW-1:0] ax, ay, mn, mx;
  logic            swap;
  vdb_div_t        prep_r, prep_nxt;

  // twos complement negate; -2048 comes out as 2048 in 12 unsigned bits
  assign ax   = x_value[CompW-1] ? MagW'(~x_value + 1'b1) : MagW'(x_value);
  assign ay   = y_value[CompW-1] ? MagW'(~y_value + 1'b1) : MagW'(y_value);
  assign swap = ax > ay;
  assign mn   = swap ? ay : ax;
  assign mx   = swap ? ax : ay;

  always_comb begin
    prep_nxt      = '0;
    prep_nxt.rem  = RemW'(mn) * RemW'(Eighth);
    prep_nxt.den  = mx;
    prep_nxt.quo  = '0;
    prep_nxt.swap = swap;
    prep_nxt.xneg = x_value[CompW-1];
    prep_nxt.yneg = y_value[CompW-1];
    prep_nxt.zero = (ax == '0) && (ay == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign dout = prep_r;

endmodule

// ===== hw/rtl/vdb_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdb_divider
// pipelined restoring divider, two quotient bits per stage
// ----------------------------------------------------------------------------
module vdb_divider import vdb_pkg::*; (
  input  logic                 clk,
  input  logic [DivStages-1:0] en,
  input  vdb_div_t             din,
  output vdb_div_t             dout
);

  vdb_div_t src [DivStages+1];
  vdb_div_t stg_r [DivStages];
  vdb_div_t stg_nxt [DivStages];

  assign src[0] = din;

  for (genvar g = 0; g < DivStages; g++) begin : g_stage
    always_comb begin
      logic [RemW-1:0] dsh;
      int              b;
      stg_nxt[g] = src[g];
      dsh        = '0;
      for (int k = 0; k < DivBitsPerStage; k++) begin
        b   = QuoW - 1 - g * DivBitsPerStage - k;
        dsh = RemW'(src[g].den) << b;
        if (stg_nxt[g].rem >= dsh) begin
          stg_nxt[g].rem = stg_nxt[g].rem - dsh;
          stg_nxt[g].quo[b[$clog2(QuoW)-1:0]] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        stg_r[g] <= stg_nxt[g];
      end
    end

    assign src[g+1] = stg_r[g];
  end

  assign dout = src[DivStages];

endmodule

// ===== hw/rtl/vdb_place.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdb_place
// last stage: curve correction, octant mirror and quadrant placement
// ----------------------------------------------------------------------------
module vdb_place import vdb_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  vdb_div_t        din,
  output logic [BrgW-1:0] bearing_degrees,
  output logic            invalid
);

  logic [QuoW-1:0] q;
  logic [2:0]      corr;
  logic [6:0]      v, oct;
  logic [BrgW-1:0] qq;
  logic [BrgW-1:0] brg_r, brg_nxt;
  logic            inv_r;

  assign q = din.quo;

  always_comb begin
    if (q > CorrSplit) begin
      corr = 3'(q <= CorrHi0) + 3'(q <= CorrHi1) + 3'(q <= CorrHi2) + 3'(q <= CorrHi3);
    end else begin
      corr = 3'(q >= CorrLo0) + 3'(q >= CorrLo1) + 3'(q >= CorrLo2) + 3'(q >= CorrLo3);
    end
  end

  assign v   = 7'(q) + 7'(corr);
  assign oct = din.swap ? (Quarter - v) : v;
  assign qq  = BrgW'(oct);

  always_comb begin
    priority if (din.zero) begin
      brg_nxt = '0;
    end else if (din.yneg) begin
      brg_nxt = din.xneg ? (HalfTurn + qq) : (HalfTurn - qq);
    end else begin
      brg_nxt = din.xneg ? (FullTurn - qq) : qq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      brg_r <= brg_nxt;
      inv_r <= din.zero;
    end
  end

  assign bearing_degrees = brg_r;
  assign invalid         = inv_r;

endmodule

// ===== hw/rtl/vector_to_degree_bearing_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_to_degree_bearing_unit
// signed xy vector to whole-degree bearing, clockwise from +y
// ----------------------------------------------------------------------------
// usage:
//   input word: in_tdata carries x (bits 11:0) and y (bits 23:12), both
//   signed. result word: out_tdata bits 8:0 hold the bearing 0..360,
//   out_tuser is set for the zero vector, whose bearing reads 0.
//   five register stages: operand prep with the 45x multiply, three
//   divider stages of two quotient bits each, then correction and
//   quadrant placement into the output register that feeds out_tdata.
//   one word per cycle is sustained as long as out_tready stays high;
//   every stage holds one word, so the pipeline holds five words at most.
//   when the receiver stalls, stages fill from the output backward and
//   empty stages still take words; in_tready drops only when all five
//   stages hold data. reset empties the pipeline; no results are pending
//   afterwards and in_tready is high.
// ----------------------------------------------------------------------------
module vector_to_degree_bearing_unit import vdb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // x_value[11:0], y_value[23:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // bearing_degrees[8:0], zero pad[15:9]
  output logic        out_tuser   // invalid
);

  logic [NumStages-1:0] vld_r, vld_nxt;
  logic [NumStages-1:0] en;
  vdb_div_t             prep_w, div_w;
  logic [BrgW-1:0]      bearing_degrees;
  logic                 invalid;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[NumStages-1] = !vld_r[NumStages-1] || out_tready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_tvalid;
    end
    for (int i = 1; i < NumStages; i++) begin
      if (en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  vdb_prep u_prep (
    .clk     (clk),
    .en      (en[0]),
    .x_value (in_tdata[11:0]),
    .y_value (in_tdata[23:12]),
    .dout    (prep_w)
  );

  vdb_divider u_div (
    .clk  (clk),
    .en   (en[DivStages:1]),
    .din  (prep_w),
    .dout (div_w)
  );

  vdb_place u_place (
    .clk             (clk),
    .en              (en[NumStages-1]),
    .din             (div_w),
    .bearing_degrees (bearing_degrees),
    .invalid         (invalid)
  );

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NumStages-1];
  assign out_tdata  = {7'b0, bearing_degrees};
  assign out_tuser  = invalid;

`ifndef SYNTHESIS
  a_zero_vector_bearing : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[8:0] == '0)
    else $error("zero vector word with nonzero bearing");

  a_bearing_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:0] <= FullTurn)
    else $error("bearing above full turn");

  a_ready_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> &vld_r)
    else $error("input stalled while a stage is empty");

  a_reset_empties : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");
`endif

endmodule
